// File: sv/tsdf_pkg.sv
// Shared types and constants of the text stream display filter.
package tsdf_pkg;

   localparam int NUMBER_DIGITS = 6;
   localparam int BODY_MAX      = 4;
   localparam int BODY_LEN_W    = $clog2(BODY_MAX + 1);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SEQ_MAX       = (NUMBER_DIGITS > BODY_MAX) ? NUMBER_DIGITS : BODY_MAX;
   localparam int SEQ_CNT_W     = $clog2(SEQ_MAX + 1);
   localparam int DIGIT_IDX_W   = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
   localparam int BODY_IDX_W    = $clog2(BODY_MAX);
   localparam int CSR_INDEX_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_NONBLANK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_ALL       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_BLANK    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_ENDS        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TABS        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_NONPRINTING = 3'd5;

   localparam logic [7:0] BYTE_NL      = 8'h0A;
   localparam logic [7:0] BYTE_TAB     = 8'h09;
   localparam logic [7:0] BYTE_DEL     = 8'h7F;
   localparam logic [7:0] BYTE_CTRL_HI = 8'h20;
   localparam logic [7:0] CTRL_FLIP    = 8'h40;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_CARET   = 8'h5E;
   localparam logic [7:0] CHAR_I       = 8'h49;
   localparam logic [7:0] CHAR_M       = 8'h4D;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_QMARK   = 8'h3F;

   localparam logic [NUMBER_DIGITS-1:0][3:0] COUNT_ONE = (NUMBER_DIGITS * 4)'(1);

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   typedef struct packed {
      logic                               has_prefix;
      logic [NUMBER_DIGITS-1:0][7:0]      prefix_chars;
      logic                               has_dollar;
      logic [BODY_MAX-1:0][7:0]           body;
      logic [BODY_LEN_W-1:0]              body_len;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic active;
   } back_status_type;

endpackage

// File: sv/tsdf_front.sv
// Front end: accepts text bytes, tracks line state and builds display jobs.
module tsdf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  tsdf_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_first_of_file,
   input  tsdf_pkg::q_status_type  q_status,
   output logic                    push,
   output tsdf_pkg::job_type       push_job
);
   import tsdf_pkg::*;

   logic [7:0]                     prev_ff, prev_in;
   logic [NUMBER_DIGITS-1:0][3:0]  digits_ff, digits_in;
   logic                           after_empty_ff, after_empty_in;

   logic                           accept;
   logic                           is_nl;
   logic                           prev_nl;
   logic                           squeezed;
   logic                           prefix;
   logic                           all_nines;
   logic                           carry;
   logic                           started;
   logic [NUMBER_DIGITS-1:0][3:0]  count_cur;
   logic [NUMBER_DIGITS-1:0][3:0]  count_inc;
   logic [3:0]                     digit;
   logic [6:0]                     low7;
   logic [1:0][7:0]                rest;
   logic [1:0]                     rest_len;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_nl     = (req_in_byte == BYTE_NL);
      prev_nl   = req_first_of_file || (prev_ff == BYTE_NL);
      count_cur = req_first_of_file ? COUNT_ONE : digits_ff;
      squeezed  = cfg.squeeze_blank && is_nl && after_empty_ff;
      prefix    = cfg.number_nonblank ? (prev_nl && !is_nl) : (cfg.number_all && prev_nl);

      all_nines = 1'b1;
      carry     = 1'b1;
      count_inc = count_cur;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         all_nines = all_nines && (count_cur[i] == 4'd9);
         if (carry) begin
            if (count_cur[i] == 4'd9) begin
               count_inc[i] = 4'd0;
            end else begin
               count_inc[i] = count_cur[i] + 4'd1;
               carry        = 1'b0;
            end
         end
      end

      push_job = '0;
      push_job.has_prefix = prefix;
      started = 1'b0;
      for (int j = 0; j < NUMBER_DIGITS; j++) begin
         digit   = count_cur[NUMBER_DIGITS-1-j];
         started = started || (digit != 4'd0) || (j == NUMBER_DIGITS - 1);
         push_job.prefix_chars[j] = started ? (CHAR_ZERO + {4'd0, digit}) : CHAR_SPACE;
      end
      push_job.has_dollar = cfg.show_ends && is_nl;

      low7 = req_in_byte[6:0];
      if ((low7 < BYTE_CTRL_HI[6:0]) || (low7 == BYTE_DEL[6:0])) begin
         rest[0]  = CHAR_CARET;
         rest[1]  = (low7 == BYTE_DEL[6:0]) ? CHAR_QMARK : ({1'b0, low7} | CTRL_FLIP);
         rest_len = 2'd2;
      end else begin
         rest[0]  = {1'b0, low7};
         rest[1]  = CHAR_SPACE;
         rest_len = 2'd1;
      end

      if (cfg.show_tabs && (req_in_byte == BYTE_TAB)) begin
         push_job.body[0]  = CHAR_CARET;
         push_job.body[1]  = CHAR_I;
         push_job.body_len = BODY_LEN_W'(2);
      end else if (cfg.show_nonprinting && !is_nl && (req_in_byte != BYTE_TAB)) begin
         if (req_in_byte[7]) begin
            push_job.body[0]  = CHAR_M;
            push_job.body[1]  = CHAR_DASH;
            push_job.body[2]  = rest[0];
            push_job.body[3]  = rest[1];
            push_job.body_len = BODY_LEN_W'(rest_len) + BODY_LEN_W'(2);
         end else begin
            push_job.body[0]  = rest[0];
            push_job.body[1]  = rest[1];
            push_job.body_len = BODY_LEN_W'(rest_len);
         end
      end else begin
         push_job.body[0]  = req_in_byte;
         push_job.body_len = BODY_LEN_W'(1);
      end

      push           = accept && !squeezed;
      prev_in        = req_in_byte;
      digits_in      = (!squeezed && prefix && !all_nines) ? count_inc : count_cur;
      after_empty_in = squeezed ? after_empty_ff : (prev_nl && is_nl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= BYTE_NL;
         digits_ff      <= COUNT_ONE;
         after_empty_ff <= 1'b0;
      end else if (accept) begin
         prev_ff        <= prev_in;
         digits_ff      <= digits_in;
         after_empty_ff <= after_empty_in;
      end
   end

endmodule

// File: sv/tsdf_queue.sv
// Short job queue between the front end and the output sequencer.
module tsdf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tsdf_pkg::job_type       push_job,
   input  logic                    pop,
   output tsdf_pkg::job_type       pop_job,
   output tsdf_pkg::q_status_type  status
);
   import tsdf_pkg::*;

   job_type                  store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      pop_job      = store_ff[rd_ptr_ff];
      wr_ptr_in    = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in    = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/tsdf_back.sv
// Output sequencer: walks one job and sends its display bytes one per cycle while rsp_ready allows.
module tsdf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tsdf_pkg::q_status_type    q_status,
   input  tsdf_pkg::job_type         pop_job,
   output logic                      pop,
   output tsdf_pkg::back_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_run
);
   import tsdf_pkg::*;

   localparam logic [1:0] PH_PREFIX = 2'd0;
   localparam logic [1:0] PH_TAB    = 2'd1;
   localparam logic [1:0] PH_DOLLAR = 2'd2;
   localparam logic [1:0] PH_BODY   = 2'd3;

   job_type                job_ff;
   logic                   active_ff, active_in;
   logic [1:0]             phase_ff, phase_in;
   logic [SEQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_byte_ff;
   logic                   rsp_last_ff;

   logic                   advance;
   logic                   done;
   logic [7:0]             cur_byte;
   logic [1:0]             next_phase;
   logic [SEQ_CNT_W-1:0]   next_cnt;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign status.active   = active_ff;

   always_comb begin
      advance    = !rsp_valid_ff || rsp_ready;
      done       = 1'b0;
      cur_byte   = CHAR_SPACE;
      next_phase = phase_ff;
      next_cnt   = '0;
      unique case (phase_ff)
         PH_PREFIX: begin
            cur_byte = job_ff.prefix_chars[cnt_ff[DIGIT_IDX_W-1:0]];
            if (cnt_ff == SEQ_CNT_W'(NUMBER_DIGITS - 1)) begin
               next_phase = PH_TAB;
            end else begin
               next_cnt = cnt_ff + 1'b1;
            end
         end
         PH_TAB: begin
            cur_byte   = BYTE_TAB;
            next_phase = job_ff.has_dollar ? PH_DOLLAR : PH_BODY;
         end
         PH_DOLLAR: begin
            cur_byte   = CHAR_DOLLAR;
            next_phase = PH_BODY;
         end
         PH_BODY: begin
            cur_byte = job_ff.body[cnt_ff[BODY_IDX_W-1:0]];
            next_cnt = cnt_ff + 1'b1;
            done     = (next_cnt == SEQ_CNT_W'(job_ff.body_len));
         end
         default: begin
            next_phase = PH_BODY;
         end
      endcase

      pop       = advance && (!active_ff || done) && !q_status.empty;
      active_in = active_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      if (pop) begin
         active_in = 1'b1;
         cnt_in    = '0;
         if (pop_job.has_prefix) begin
            phase_in = PH_PREFIX;
         end else if (pop_job.has_dollar) begin
            phase_in = PH_DOLLAR;
         end else begin
            phase_in = PH_BODY;
         end
      end else if (advance && active_ff) begin
         active_in = !done;
         phase_in  = next_phase;
         cnt_in    = next_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_job;
      end
      if (advance) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         phase_ff     <= PH_BODY;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         if (advance) begin
            rsp_valid_ff <= active_ff;
         end
      end
   end

endmodule

// File: sv/text_stream_display_filter.sv
// Top level of the text stream display filter: settings, front end, job queue and output sequencer.
// An input byte is taken in the cycle it arrives whenever the four-entry job queue has room,
// and its display bytes leave one per cycle through the registered output while rsp_ready
// is high: plain bytes run at one per cycle, a line-number prefix adds six digit bytes and
// a tab, and caret or M- forms add one to three bytes. The single output byte lane sets the
// throughput; the first byte of an item passes the job queue, the sequencer's job register
// and the output register. A squeezed blank line produces no output but takes an input transfer.
// The user writes settings through the csr port only while the block is idle; nothing enforces it.
module text_stream_display_filter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_first_of_file,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last_of_run,
   input  logic                             csr_we,
   input  logic [tsdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                             csr_wdata
);
   import tsdf_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          pop_job;
   q_status_type     q_status;
   back_status_type  back_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_wdata;
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_wdata;
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_wdata;
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_wdata;
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_wdata;
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsdf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_first_of_file (req_first_of_file),
      .q_status          (q_status),
      .push              (push),
      .push_job          (push_job)
   );

   tsdf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   tsdf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop_job         (pop_job),
      .pop             (pop),
      .status          (back_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job popped from an empty queue");

   a_mid_run_keeps_job: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> back_status.active)
      else $error("display run ended without a final transfer");

   a_idle_output_empty: assert property (@(posedge clock) disable iff (reset)
      (!back_status.active && q_status.empty && rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("output shows a byte with no job behind it");

endmodule

// File: dv/tsdf_display_checker.sv
// Checker for the text stream display filter: predicts display bytes and compares each transfer.
module tsdf_display_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_first_of_file,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [7:0]                       rsp_out_byte,
   input  logic                             rsp_last_of_run,
   input  logic                             csr_we,
   input  logic [tsdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                             csr_wdata,
   output int unsigned                      mismatch_count,
   output int unsigned                      expected_left
);

   timeunit 1ns;
   timeprecision 1ps;

   import tsdf_pkg::*;

   localparam int unsigned LINE_LIMIT = 10 ** NUMBER_DIGITS - 1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } display_entry_type;

   display_entry_type display_q[$];
   cfg_type           settings;
   logic [7:0]        prev_byte;
   logic [19:0]       line_number;
   logic              after_empty;

   task automatic predict_display(input logic [7:0] ch, input logic first);
      logic       prev_nl;
      logic       is_nl;
      logic       prefix;
      logic       started;
      logic [7:0] c;
      logic [7:0] digit_chars[NUMBER_DIGITS];
      logic [7:0] run_bytes[$];
      int unsigned v;
      if (first) begin
         line_number = 20'd1;
         prev_byte   = BYTE_NL;
      end
      prev_nl = (prev_byte == BYTE_NL);
      is_nl   = (ch == BYTE_NL);
      if (!(settings.squeeze_blank && is_nl && after_empty)) begin
         prefix = settings.number_nonblank ? (prev_nl && !is_nl)
                                           : (settings.number_all && prev_nl);
         if (prefix) begin
            v = line_number;
            for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
               digit_chars[i] = 8'(CHAR_ZERO + v % 10);
               v = v / 10;
            end
            started = 1'b0;
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
               if (digit_chars[i] != CHAR_ZERO || i == NUMBER_DIGITS - 1) begin
                  started = 1'b1;
               end
               run_bytes.push_back(started ? digit_chars[i] : CHAR_SPACE);
            end
            run_bytes.push_back(BYTE_TAB);
            if (line_number < LINE_LIMIT) begin
               line_number = line_number + 20'd1;
            end
         end
         after_empty = prev_nl && is_nl;
         if (settings.show_ends && is_nl) begin
            run_bytes.push_back(CHAR_DOLLAR);
         end
         if (settings.show_tabs && ch == BYTE_TAB) begin
            run_bytes.push_back(CHAR_CARET);
            run_bytes.push_back(CHAR_I);
         end else if (settings.show_nonprinting && !is_nl && ch != BYTE_TAB) begin
            c = ch;
            if (c[7]) begin
               run_bytes.push_back(CHAR_M);
               run_bytes.push_back(CHAR_DASH);
               c[7] = 1'b0;
            end
            if (c < BYTE_CTRL_HI || c == BYTE_DEL) begin
               run_bytes.push_back(CHAR_CARET);
               run_bytes.push_back((c == BYTE_DEL) ? CHAR_QMARK : (c | CTRL_FLIP));
            end else begin
               run_bytes.push_back(c);
            end
         end else begin
            run_bytes.push_back(ch);
         end
      end
      prev_byte = ch;
      for (int i = 0; i < run_bytes.size(); i++) begin
         display_q.push_back('{out_byte: run_bytes[i], last_of_run: (i == run_bytes.size() - 1)});
      end
   endtask

   always @(posedge clock) begin
      display_entry_type oldest;
      if (reset) begin
         settings       = '0;
         prev_byte      = BYTE_NL;
         line_number    = 20'd1;
         after_empty    = 1'b0;
         mismatch_count = 0;
         display_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUMBER_NONBLANK:  settings.number_nonblank  = csr_wdata;
               CSR_NUMBER_ALL:       settings.number_all       = csr_wdata;
               CSR_SQUEEZE_BLANK:    settings.squeeze_blank    = csr_wdata;
               CSR_SHOW_ENDS:        settings.show_ends        = csr_wdata;
               CSR_SHOW_TABS:        settings.show_tabs        = csr_wdata;
               CSR_SHOW_NONPRINTING: settings.show_nonprinting = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (display_q.size() == 0) begin
               $error("out_byte: expected none, actual %02h", rsp_out_byte);
               mismatch_count++;
            end else begin
               oldest = display_q.pop_front();
               if (rsp_out_byte !== oldest.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", oldest.out_byte, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last_of_run !== oldest.last_of_run) begin
                  $error("last_of_run: expected %0b, actual %0b",
                         oldest.last_of_run, rsp_last_of_run);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_display(req_in_byte, req_first_of_file);
         end
      end
      expected_left <= display_q.size();
   end

endmodule

// File: dv/text_stream_display_filter_tb.sv
// Testbench top for the text stream display filter: clock, reset, settings, text and verdict.
module text_stream_display_filter_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import tsdf_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 12;

   typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_SPARSE} ready_pattern_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_in_byte;
   logic                   req_first_of_file;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_last_of_run;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_wdata;
   int unsigned            mismatch_count;
   int unsigned            expected_left;
   int unsigned            cycle_count;
   bit                     hold_off_wanted;

   text_stream_display_filter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_first_of_file (req_first_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   tsdf_display_checker i_display_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_first_of_file (req_first_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .expected_left     (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[text_stream_display_filter] ERROR");
         $finish;
      end
   end

   initial begin
      ready_pattern_type pattern;
      int                stretch;
      rsp_ready = 1'b0;
      forever begin
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         pattern = ready_pattern_type'($urandom_range(0, 3));
         stretch = $urandom_range(5, 30);
         repeat (stretch) begin
            @(posedge clock);
            case (pattern)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_ready <= ($urandom_range(0, 4) != 0);
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic put_setting(input logic [CSR_INDEX_W-1:0] index, input logic data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      put_setting(CSR_NUMBER_NONBLANK, s.number_nonblank);
      put_setting(CSR_NUMBER_ALL, s.number_all);
      put_setting(CSR_SQUEEZE_BLANK, s.squeeze_blank);
      put_setting(CSR_SHOW_ENDS, s.show_ends);
      put_setting(CSR_SHOW_TABS, s.show_tabs);
      put_setting(CSR_SHOW_NONPRINTING, s.show_nonprinting);
      put_setting(CSR_INDEX_W'($urandom_range(CSR_SHOW_NONPRINTING + 1, 7)),
                  1'($urandom_range(0, 1)));
      csr_we <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic first);
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_first_of_file <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_text_byte(input logic [7:0] prev_char);
      int pick;
      pick = $urandom_range(0, 99);
      if (prev_char == BYTE_NL && pick < 40) begin
         return BYTE_NL;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         return BYTE_NL;
      end else if (pick < 22) begin
         return BYTE_TAB;
      end else if (pick < 70) begin
         return 8'($urandom_range(8'h20, 8'h7E));
      end else if (pick < 80) begin
         return 8'($urandom_range(8'h00, 8'h1F));
      end else if (pick < 85) begin
         return BYTE_DEL;
      end
      return 8'($urandom_range(8'h80, 8'hFF));
   endfunction

   task automatic run_random_text(input int count);
      int         sent;
      int         burst;
      logic [7:0] b;
      logic [7:0] last_b;
      sent   = 0;
      last_b = BYTE_NL;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && sent < count) begin
            b = random_text_byte(last_b);
            send_byte(b, ($urandom_range(0, 29) == 0));
            last_b = b;
            sent++;
            burst--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   initial begin
      cycle_count       = 0;
      hold_off_wanted   = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_in_byte       = 8'h00;
      req_first_of_file = 1'b0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_settings(cfg_type'(6'b000000));
      send_byte(8'h61, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(BYTE_TAB, 1'b0);
      send_byte(BYTE_NL, 1'b0);
      settle();

      apply_settings(cfg_type'(6'b111111));
      send_byte(8'h41, 1'b1);
      send_byte(BYTE_TAB, 1'b0);
      send_byte(BYTE_DEL, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h8A, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(BYTE_NL, 1'b0);
      send_byte(BYTE_NL, 1'b0);
      send_byte(BYTE_NL, 1'b0);
      send_byte(BYTE_NL, 1'b1);
      send_byte(8'h7A, 1'b0);
      send_byte(BYTE_NL, 1'b0);
      settle();

      apply_settings('{number_all: 1'b1, show_nonprinting: 1'b1, default: 1'b0});
      send_byte(BYTE_NL, 1'b0);
      send_byte(BYTE_TAB, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(BYTE_NL, 1'b0);
      send_byte(8'h62, 1'b1);
      send_byte(BYTE_NL, 1'b0);
      settle();

      apply_settings(cfg_type'(6'b111111));
      run_random_text(30);
      settle();

      apply_settings(cfg_type'(6'($urandom)));
      run_random_text(30);
      settle();

      apply_settings('{number_all: 1'b1, squeeze_blank: 1'b1, default: 1'b0});
      hold_off_wanted = 1'b1;
      run_random_text(40);
      settle();

      apply_settings(cfg_type'(6'b000000));
      run_random_text(25);
      settle();

      repeat (2) begin
         apply_settings(cfg_type'(6'($urandom)));
         run_random_text(28);
         settle();
      end

      if (mismatch_count == 0) begin
         $display("[text_stream_display_filter] OK");
      end else begin
         $display("[text_stream_display_filter] ERROR");
      end
      $finish;
   end

endmodule

// File: text_stream_display_filter.f
sv/tsdf_pkg.sv
sv/tsdf_front.sv
sv/tsdf_queue.sv
sv/tsdf_back.sv
sv/text_stream_display_filter.sv
dv/tsdf_display_checker.sv
dv/text_stream_display_filter_tb.sv
